### design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing else.
package spq_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    // Request codes carried in the kind field.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Register index of the order mode register.
    localparam logic REG_ORDER = 1'b0;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                     push;
        logic                     pop;
        logic                     descending;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

### design/spq_cell.sv
// One slot of the sorted chain: holds one entry and shifts with its neighbors.
// Depends on spq_pkg for the command struct and data width.
module spq_cell (
    input  logic                             clk,
    input  spq_pkg::cell_cmd_t               cmd,
    input  logic                             occupied,
    input  logic                             prev_behind,
    input  logic signed [spq_pkg::DATA_W-1:0] prev_entry,
    input  logic signed [spq_pkg::DATA_W-1:0] next_entry,
    output logic                             behind,
    output logic signed [spq_pkg::DATA_W-1:0] entry,
    output logic signed [spq_pkg::DATA_W-1:0] entry_next
);
    import spq_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;

    // The incoming value belongs behind this entry when the entry is closer
    // to the top in the current order. Equal values go in front.
    always_comb
    begin
        if (cmd.descending)
        begin
            behind = occupied && (entry_reg > cmd.value);
        end
        else
        begin
            behind = occupied && (entry_reg < cmd.value);
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.push)
        begin
            if (!behind)
            begin
                entry_next = prev_behind ? cmd.value : prev_entry;
            end
        end
        else if (cmd.pop)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### design/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, count, result register
// and APB register. Depends on spq_pkg and spq_cell.
//
// Usage:
//   The input channel (in_valid/in_ready, fields kind and value) carries one
//   request per transaction: a push inserts value in order, a pop removes
//   the top entry. Every input transaction yields exactly one result
//   transaction on the output channel (out_valid/out_ready) describing the
//   queue after the request: top_value, top_valid, entry_count and status.
//   The result is registered at the edge that accepts the request.
//   Throughput is one request per cycle while the receiver keeps up; the
//   whole chain of compare-and-shift cells updates at that same edge.
//   When the receiver stalls, the result register holds its transaction and
//   in_ready drops until it is taken, so no result is lost or repeated.
//   The APB register order_descending (address 0) selects the order: 0 keeps
//   the smallest value on top, 1 the largest. Writes are ignored unless the
//   queue is empty. pready is always high.
//   Reset clears the entry count, the order mode and the result valid flag;
//   the entry storage itself is not cleared, since only entries below the
//   count are ever read.
module sorted_priority_queue #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic signed [spq_pkg::DATA_W-1:0]  value,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [spq_pkg::DATA_W-1:0]  top_value,
    output logic                              top_valid,
    output logic [spq_pkg::COUNT_W-1:0]       entry_count,
    output logic [1:0]                        status,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import spq_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      order_reg;
    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  top_value_reg;
    logic                      top_valid_reg;
    logic [COUNT_W-1:0]        entry_count_reg;
    status_t                   status_reg;
    status_t                   status_next;

    logic                      in_fire;
    logic                      is_full;
    logic                      is_empty;
    cell_cmd_t                 cmd;
    logic                      cfg_write;

    logic signed [DATA_W-1:0]  entry_q    [CAPACITY];
    logic signed [DATA_W-1:0]  entry_d    [CAPACITY];
    logic                      behind     [CAPACITY];

    // The result register parts the two channels: a new request is taken
    // whenever the pending result is taken in the same cycle or none waits.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        cmd.push       = in_fire && (kind == KIND_PUSH) && !is_full;
        cmd.pop        = in_fire && (kind == KIND_POP) && !is_empty;
        cmd.descending = order_reg;
        cmd.value      = value;
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        if (kind == KIND_PUSH)
        begin
            if (is_full)
            begin
                status_next = ST_PUSH_FULL;
            end
        end
        else if (is_empty)
        begin
            status_next = ST_POP_EMPTY;
        end
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Chain of cells: each sees the insertion flag and entry of the cell
    // above it and the entry of the cell below it.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                     prev_behind_w;
        logic signed [DATA_W-1:0] prev_entry_w;
        logic signed [DATA_W-1:0] next_entry_w;

        if (i == 0)
        begin : g_head
            assign prev_behind_w = 1'b1;
            assign prev_entry_w  = value;
        end
        else
        begin : g_body
            assign prev_behind_w = behind[i-1];
            assign prev_entry_w  = entry_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_entry_w = entry_q[i];
        end
        else
        begin : g_inner
            assign next_entry_w = entry_q[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (count_reg > CNT_W'(i)),
            .prev_behind (prev_behind_w),
            .prev_entry  (prev_entry_w),
            .next_entry  (next_entry_w),
            .behind      (behind[i]),
            .entry       (entry_q[i]),
            .entry_next  (entry_d[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: loaded with the state after the request.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            top_valid_reg   <= (count_next != '0);
            top_value_reg   <= (count_next != '0) ? entry_d[0] : '0;
            entry_count_reg <= COUNT_W'(count_next);
            status_reg      <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign top_value   = top_value_reg;
    assign top_valid   = top_valid_reg;
    assign entry_count = entry_count_reg;
    assign status      = status_reg;

    // Configuration register. The order may only change on an empty queue.
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ORDER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 1'b0;
        end
        else if (cfg_write && is_empty)
        begin
            order_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_ORDER) ? {31'b0, order_reg} : 32'b0;
    assign pready = 1'b1;

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_push_grows : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (kind == KIND_PUSH) && !is_full |=>
            count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted push did not grow the queue");

    a_full_holds : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (kind == KIND_PUSH) && is_full |=>
            count_reg == $past(count_reg) && status_reg == ST_PUSH_FULL)
        else $error("push on full queue changed the count");

    a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted request produced no result");

    a_empty_pop_flag : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == ST_POP_EMPTY) |-> !top_valid_reg)
        else $error("pop on empty queue reported a top entry");
`endif

endmodule

### verif/sorted_priority_queue_tb.sv
// Self-checking testbench for sorted_priority_queue: directed and random push/pop traffic
// with random stalls on both channels, order mode changes over APB, scoreboard checks.
// Depends on spq_pkg and the sorted_priority_queue design; needs no other files.
module sorted_priority_queue_tb;

    import spq_pkg::*;

    localparam int unsigned CAPACITY = 16;
    localparam int unsigned MAX_WAIT = 18;

    // The order register is index 0 at byte address 0; index 1 holds no register.
    localparam logic [2:0] ADDR_ORDER = {REG_ORDER, 2'b00};
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     kind;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] top_value;
    logic                     top_valid;
    logic [COUNT_W-1:0]       entry_count;
    logic [1:0]               status;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [2:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    // One predicted result transaction.
    typedef struct {
        logic signed [DATA_W-1:0] top_value;
        logic                     top_valid;
        logic [COUNT_W-1:0]       entry_count;
        status_t                  status;
    } queue_result_t;

    // Scoreboard: keeps its own sorted copy of the queue and the order mode, predicts the
    // result of every accepted request and compares the results in arrival order.
    class queue_scoreboard;
        logic signed [DATA_W-1:0] entries [CAPACITY];
        int                       held;
        logic                     descending;
        queue_result_t            pending_results [$];
        int                       errors;

        function new();
            held       = 0;
            descending = 1'b0;
            errors     = 0;
        endfunction

        // True while the incoming value belongs behind the existing entry.
        function bit goes_behind(logic signed [DATA_W-1:0] existing,
                                 logic signed [DATA_W-1:0] incoming);
            return descending ? (existing > incoming) : (existing < incoming);
        endfunction

        function void note_request(logic req_kind, logic signed [DATA_W-1:0] req_value);
            queue_result_t r;
            int            pos;
            r.status = ST_OK;
            if (req_kind == KIND_PUSH)
            begin
                if (held >= CAPACITY)
                begin
                    r.status = ST_PUSH_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < held && goes_behind(entries[pos], req_value))
                        pos++;
                    for (int i = held; i > pos; i--)
                        entries[i] = entries[i-1];
                    entries[pos] = req_value;
                    held++;
                end
            end
            else if (held == 0)
            begin
                r.status = ST_POP_EMPTY;
            end
            else
            begin
                for (int i = 0; i + 1 < held; i++)
                    entries[i] = entries[i+1];
                held--;
            end
            r.top_value   = (held != 0) ? entries[0] : '0;
            r.top_valid   = (held != 0);
            r.entry_count = COUNT_W'(held);
            pending_results.push_back(r);
        endfunction

        // The order mode only changes while the queue is empty, and only bit 0 counts.
        function void write_register(logic [2:0] addr, logic [31:0] data);
            if (addr == ADDR_ORDER && held == 0)
                descending = data[0];
        endfunction

        function void check_result(logic signed [DATA_W-1:0] got_top, logic got_valid,
                                   logic [COUNT_W-1:0] got_count, logic [1:0] got_status);
            queue_result_t r;
            if (pending_results.size() == 0)
            begin
                $error("result transaction arrived with no request outstanding");
                errors++;
                return;
            end
            r = pending_results.pop_front();
            if (got_top !== r.top_value)
            begin
                $error("top_value: expected %0d, got %0d", r.top_value, got_top);
                errors++;
            end
            if (got_valid !== r.top_valid)
            begin
                $error("top_valid: expected %0d, got %0d", r.top_valid, got_valid);
                errors++;
            end
            if (got_count !== r.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", r.entry_count, got_count);
                errors++;
            end
            if (got_status !== r.status)
            begin
                $error("status: expected %0d, got %0d", r.status, got_status);
                errors++;
            end
        endfunction
    endclass

    queue_scoreboard board;

    // When set, neither side idles, so requests and results run back to back.
    bit burst;

    sorted_priority_queue #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .top_value  (top_value),
        .top_valid  (top_valid),
        .entry_count(entry_count),
        .status     (status),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle cycles ahead of one transaction. At least a quarter of the draws are zero even outside
    // burst stretches, so short back-to-back runs also appear in the idling phases.
    function automatic int unsigned draw_wait();
        if (burst || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Values lean toward the extremes and a narrow band around zero, where duplicates
    // are frequent; the rest are full-width random words so every bit toggles.
    function automatic logic signed [DATA_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return DATA_W'(int'($urandom_range(0, 2)) - 1);
            3, 4, 5: return DATA_W'(int'($urandom_range(0, 20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    // Offers one request transaction and returns at the edge that accepts it. Valid is left
    // high so that a following request with no gap keeps it asserted without a glitch.
    task automatic send_request(input logic req_kind, input logic signed [DATA_W-1:0] req_value);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= req_kind;
        value    <= req_value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_request(req_kind, req_value);
    endtask

    // Drops valid and waits until every outstanding result has been taken. The block
    // registers each result at the edge that accepts its request.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // One APB transaction: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        if (wr)
            board.write_register(addr, wdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Reads the order register back and compares it with the predicted mode.
    task automatic check_order_register();
        logic [31:0] rdata;
        apb_access(1'b0, ADDR_ORDER, '0, rdata);
        if (rdata !== {31'b0, board.descending})
        begin
            $error("order_descending: expected %0d, got %0d", board.descending, rdata);
            board.errors++;
        end
    endtask

    // Moves to a new order mode. With drain clear the queue may still hold entries, and
    // the write must then be ignored. A write to the unused index comes first and must
    // leave the mode alone; upper data bits are random since only bit 0 is used.
    task automatic change_order(input bit drain, input logic target);
        logic [31:0] rdata;
        if (drain)
            while (board.held != 0) send_request(KIND_POP, $urandom);
        wait_idle();
        apb_access(1'b1, ADDR_SPARE, $urandom, rdata);
        apb_access(1'b1, ADDR_ORDER, {31'($urandom_range(0, 32'h7FFF_FFFF)), target}, rdata);
        check_order_register();
    endtask

    // Receiver: stalls a random number of cycles before each result transaction and
    // checks each one at the edge that takes it.
    initial
    begin
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            board.check_result(top_value, top_valid, entry_count, status);
        end
    end

    // Stimulus: a directed part on the ascending queue, then random phases that each start
    // with an order mode write.
    initial
    begin
        logic signed [DATA_W-1:0] fill_values [CAPACITY];
        logic [31:0]              rdata;
        int unsigned              push_pct;
        logic                     target;

        board = new();
        burst = 1'b0;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        kind      <= KIND_PUSH;
        value     <= '0;
        out_ready <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_access(1'b1, ADDR_ORDER, '0, rdata);
        check_order_register();

        // Pop on an empty queue is reported and changes nothing.
        send_request(KIND_POP, VAL_MAX);

        // Fill to capacity with extremes, duplicates and alternating bit patterns.
        fill_values = '{32'sd0, VAL_MIN, VAL_MAX, -32'sd1, 32'sd1, 32'sd5, 32'sd5, -32'sd5,
                        VAL_MAX, VAL_MIN, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd100,
                        -32'sd100, 32'sd7, 32'sd3};
        foreach (fill_values[i])
            send_request(KIND_PUSH, fill_values[i]);

        // Push on a full queue is dropped and reported.
        send_request(KIND_PUSH, 32'sd42);
        send_request(KIND_POP, '0);
        send_request(KIND_POP, 32'shFFFF_FFFF);

        // Order change while entries are held must be ignored; this is also the point
        // where the sender waits for every result before going on.
        wait_idle();
        apb_access(1'b1, ADDR_ORDER, 32'h0000_0001, rdata);
        check_order_register();

        // Random phases, about 75 requests each. The push share varies so the queue runs
        // full, empty, and in between; every third phase runs without idling.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       target = 1'b1;
                1:       target = 1'b0;
                2:       target = 1'b1;
                default: target = $urandom_range(0, 1);
            endcase
            change_order(phase % 4 != 3, target);

            burst = (phase % 3 == 1);
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 55;
                default: push_pct = 30;
            endcase
            for (int n = 0; n < 75; n++)
            begin
                if ($urandom_range(0, 99) < push_pct)
                    send_request(KIND_PUSH, draw_value());
                else
                    send_request(KIND_POP, $urandom);
            end
            burst = 1'b0;
        end

        wait_idle();
        repeat (5) @(posedge clk);
        if (board.errors == 0 && board.pending_results.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // The slowest correct run is well under a million time units.
    initial
    begin
        #6000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sorted_priority_queue.f
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
verif/sorted_priority_queue_tb.sv
